/* src/speculative_mod_tap_hold_assert.svh */
// assertion macros for the speculative mod-tap hold block
`ifndef SPECULATIVE_MOD_TAP_HOLD_ASSERT_SVH
`define SPECULATIVE_MOD_TAP_HOLD_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, masked while reset is asserted
`define SMTH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check that also runs through reset
`define SMTH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SMTH_ASSERT(label, prop, msg)
`define SMTH_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* src/smth_pkg.sv */
// shared types, constants and helpers for the speculative mod-tap hold block
`default_nettype none
package smth_pkg;

  localparam int MOD_W = 8;
  localparam int FIELD_W = 5;
  localparam int POS_W = 6;
  localparam int RIGHT_BIT = 4;
  localparam logic [FIELD_W-1:0] EXCL_RESET = 5'd12;

  // one list entry: key position and the mods applied ahead of time
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [MOD_W-1:0] mods;
  } entry_t;

  // datapath operations issued by the sequencer
  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_APP_SPEC,
    OP_APP_ZERO,
    OP_READ,
    OP_EVAL,
    OP_TRUNC,
    OP_HOLD,
    OP_SH_READ,
    OP_SH_WRITE,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } ctrl_t;

  typedef struct packed {
    logic kind0;
    logic pre_spec;
    logic pre_plain;
    logic pr_act;
    logic last;
    logic hold;
    logic found;
    logic sh_more;
  } flags_t;

  // right-side keys move the low nibble to the high nibble
  function automatic logic [MOD_W-1:0] expand_mods(input logic [FIELD_W-1:0] m5);
    logic [MOD_W-1:0] res;
    if (m5[RIGHT_BIT]) begin
      res = {m5[3:0], 4'b0000};
    end else begin
      res = {3'b000, m5};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* src/smth_seq.sv */
// microprogram sequencer: step counter, control store and branch logic
`default_nettype none
module smth_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire smth_pkg::flags_t flags,
  output smth_pkg::ctrl_t      ctrl,
  output logic                 busy
);
  import smth_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISP, ST_PRE, ST_PRE2, ST_APPS, ST_APPZ, ST_PR, ST_RD,
    ST_EV, ST_MODE, ST_TAP, ST_HOLD, ST_SHCHK, ST_SHRD, ST_SHWR, ST_DONE
  } step_t;

  typedef enum logic [3:0] {
    C_ALWAYS, C_START, C_KIND0, C_PRE_SPEC, C_PRE_PLAIN, C_PR_ACT,
    C_LAST, C_HOLD, C_FOUND, C_SH_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jt;
    step_t jf;
  } uword_t;

  function automatic uword_t rom(input step_t s);
    uword_t w;
    unique case (s)
      ST_IDLE:  w = '{OP_NOP,      C_START,     ST_DISP,  ST_IDLE};
      ST_DISP:  w = '{OP_INIT,     C_KIND0,     ST_PRE,   ST_PR};
      ST_PRE:   w = '{OP_NOP,      C_PRE_SPEC,  ST_APPS,  ST_PRE2};
      ST_PRE2:  w = '{OP_NOP,      C_PRE_PLAIN, ST_APPZ,  ST_DONE};
      ST_APPS:  w = '{OP_APP_SPEC, C_ALWAYS,    ST_DONE,  ST_DONE};
      ST_APPZ:  w = '{OP_APP_ZERO, C_ALWAYS,    ST_DONE,  ST_DONE};
      ST_PR:    w = '{OP_NOP,      C_PR_ACT,    ST_RD,    ST_DONE};
      ST_RD:    w = '{OP_READ,     C_ALWAYS,    ST_EV,    ST_EV};
      ST_EV:    w = '{OP_EVAL,     C_LAST,      ST_MODE,  ST_RD};
      ST_MODE:  w = '{OP_NOP,      C_HOLD,      ST_HOLD,  ST_TAP};
      ST_TAP:   w = '{OP_TRUNC,    C_ALWAYS,    ST_DONE,  ST_DONE};
      ST_HOLD:  w = '{OP_HOLD,     C_FOUND,     ST_SHCHK, ST_DONE};
      ST_SHCHK: w = '{OP_NOP,      C_SH_MORE,   ST_SHRD,  ST_DONE};
      ST_SHRD:  w = '{OP_SH_READ,  C_ALWAYS,    ST_SHWR,  ST_SHWR};
      ST_SHWR:  w = '{OP_SH_WRITE, C_ALWAYS,    ST_SHCHK, ST_SHCHK};
      ST_DONE:  w = '{OP_EMIT,     C_ALWAYS,    ST_IDLE,  ST_IDLE};
      default:  w = '{OP_NOP,      C_ALWAYS,    ST_IDLE,  ST_IDLE};
    endcase
    return w;
  endfunction

  step_t  pc_r;
  step_t  pc_nxt;
  uword_t word;
  logic   take;

  assign word = rom(pc_r);

  always_comb begin
    unique case (word.cond)
      C_ALWAYS:    take = 1'b1;
      C_START:     take = start;
      C_KIND0:     take = flags.kind0;
      C_PRE_SPEC:  take = flags.pre_spec;
      C_PRE_PLAIN: take = flags.pre_plain;
      C_PR_ACT:    take = flags.pr_act;
      C_LAST:      take = flags.last;
      C_HOLD:      take = flags.hold;
      C_FOUND:     take = flags.found;
      C_SH_MORE:   take = flags.sh_more;
      default:     take = 1'b0;
    endcase
  end

  assign pc_nxt = take ? word.jt : word.jf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign busy      = (pc_r != ST_IDLE);
  assign ctrl.load = (pc_r == ST_IDLE) && start;
  assign ctrl.op   = word.op;

endmodule
`default_nettype wire

/* src/smth_dp.sv */
// datapath: entry memory, list count, speculative mask and walk registers
`default_nettype none
`include "speculative_mod_tap_hold_assert.svh"
module smth_dp #(
  parameter int LIST_DEPTH = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire smth_pkg::ctrl_t               ctrl,
  output smth_pkg::flags_t                   flags,
  input  wire logic                          cfg_we,
  input  wire logic [smth_pkg::FIELD_W-1:0]  cfg_excluded_mod_mask,
  input  wire logic                          in_kind,
  input  wire logic                          in_pressed,
  input  wire logic                          in_is_mod_tap,
  input  wire logic                          in_is_matrix_event,
  input  wire logic [smth_pkg::POS_W-1:0]    in_key_row,
  input  wire logic [smth_pkg::POS_W-1:0]    in_key_col,
  input  wire logic [smth_pkg::FIELD_W-1:0]  in_mod_field,
  input  wire logic                          in_tap_count_zero,
  input  wire logic [smth_pkg::MOD_W-1:0]    in_current_mods,
  output logic                               out_valid,
  output logic [smth_pkg::MOD_W-1:0]         out_spec_mods_out,
  output logic [smth_pkg::MOD_W-1:0]         out_removed_mods,
  output logic                               out_send_report,
  output logic                               out_overflow_clear
);
  import smth_pkg::*;

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  // latched event word
  logic               kind_r, pressed_r, mt_r, matrix_r, hold_r;
  logic [POS_W-1:0]   row_r, col_r;
  logic [FIELD_W-1:0] m5_r;
  logic [MOD_W-1:0]   cur_r;

  entry_t             mem [LIST_DEPTH];
  entry_t             rd_data_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  logic [CNT_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   idx_r, pos_r;
  logic               found_r;
  logic [MOD_W-1:0]   spec_r, acc_all_r, acc_from_r, hold_mods_r, cleared_r;
  logic               send_r, ovf_r, out_valid_r;
  logic [FIELD_W-1:0] excl_r;

  logic [MOD_W-1:0]   exp_mods, fresh, trunc_mods;
  logic               allowed, pre_ok, full, match;
  logic [CNT_W-1:0]   idx_ext, app_cnt;
  logic [IDX_W-1:0]   idx_inc, app_addr;

  assign exp_mods   = expand_mods(m5_r);
  assign fresh      = ~(cur_r | spec_r) & exp_mods;
  assign allowed    = (m5_r & excl_r) == '0;
  assign pre_ok     = pressed_r && mt_r && matrix_r;
  assign full       = (cnt_r == CNT_W'(LIST_DEPTH));
  // a full list restarts at the front
  assign app_addr   = full ? '0 : cnt_r[IDX_W-1:0];
  assign app_cnt    = full ? CNT_W'(1) : cnt_r + CNT_W'(1);
  assign idx_ext    = CNT_W'(idx_r);
  assign idx_inc    = idx_r + IDX_W'(1);
  assign match      = (rd_data_r.row == row_r) && (rd_data_r.col == col_r);
  assign trunc_mods = found_r ? acc_from_r : acc_all_r;

  assign flags.kind0     = !kind_r;
  assign flags.pre_spec  = pre_ok && (fresh != '0) && allowed;
  assign flags.pre_plain = pre_ok && (cnt_r != '0);
  assign flags.pr_act    = (cnt_r != '0) && pressed_r;
  assign flags.last      = (idx_ext + CNT_W'(1)) == cnt_r;
  assign flags.hold      = mt_r && hold_r;
  assign flags.found     = found_r;
  // count is already decremented during a shift
  assign flags.sh_more   = idx_ext < cnt_r;

  assign rd_addr = (ctrl.op == OP_SH_READ) ? idx_inc : idx_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = app_addr;
    wr_data = '{row: row_r, col: col_r, mods: exp_mods};
    case (ctrl.op)
      OP_APP_SPEC: begin
        wr_en = 1'b1;
      end
      OP_APP_ZERO: begin
        wr_en        = 1'b1;
        wr_data.mods = '0;
      end
      OP_SH_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      spec_r      <= '0;
      excl_r      <= EXCL_RESET;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (ctrl.op == OP_EMIT);
      if (cfg_we) begin
        excl_r <= cfg_excluded_mod_mask;
      end
      case (ctrl.op)
        OP_INIT: begin
          found_r <= 1'b0;
        end
        OP_APP_SPEC: begin
          cnt_r  <= app_cnt;
          spec_r <= spec_r | exp_mods;
        end
        OP_APP_ZERO: begin
          cnt_r <= app_cnt;
        end
        OP_EVAL: begin
          if (match) begin
            found_r <= 1'b1;
          end
        end
        OP_TRUNC: begin
          cnt_r  <= found_r ? CNT_W'(pos_r) : '0;
          spec_r <= spec_r & ~trunc_mods;
        end
        OP_HOLD: begin
          if (found_r) begin
            cnt_r  <= cnt_r - CNT_W'(1);
            spec_r <= spec_r & ~hold_mods_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      kind_r    <= in_kind;
      pressed_r <= in_pressed;
      mt_r      <= in_is_mod_tap;
      matrix_r  <= in_is_matrix_event;
      row_r     <= in_key_row;
      col_r     <= in_key_col;
      m5_r      <= in_mod_field;
      hold_r    <= in_tap_count_zero;
      cur_r     <= in_current_mods;
    end
    case (ctrl.op)
      OP_INIT: begin
        idx_r      <= '0;
        acc_all_r  <= '0;
        acc_from_r <= '0;
        cleared_r  <= '0;
        send_r     <= 1'b0;
        ovf_r      <= 1'b0;
      end
      OP_APP_SPEC: begin
        ovf_r  <= full;
        send_r <= 1'b1;
      end
      OP_APP_ZERO: begin
        ovf_r <= full;
      end
      OP_EVAL: begin
        idx_r     <= idx_inc;
        acc_all_r <= acc_all_r | rd_data_r.mods;
        if (!found_r && match) begin
          pos_r       <= idx_r;
          hold_mods_r <= rd_data_r.mods;
          acc_from_r  <= rd_data_r.mods;
        end else if (found_r) begin
          acc_from_r <= acc_from_r | rd_data_r.mods;
        end
      end
      OP_TRUNC: begin
        cleared_r <= trunc_mods;
        send_r    <= (trunc_mods != '0);
      end
      OP_HOLD: begin
        if (found_r) begin
          cleared_r <= hold_mods_r;
          idx_r     <= pos_r;
        end
      end
      OP_SH_WRITE: begin
        idx_r <= idx_inc;
      end
      default: begin
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_spec_mods_out  = spec_r;
  assign out_removed_mods   = cleared_r;
  assign out_send_report    = send_r;
  assign out_overflow_clear = ovf_r;

  `SMTH_ASSERT(a_ovf_restart, ((ctrl.op == OP_APP_SPEC || ctrl.op == OP_APP_ZERO) && full |=> cnt_r == CNT_W'(1) && ovf_r), "overflow append did not restart the list")
  `SMTH_ASSERT(a_spec_grows_on_append, (ctrl.op != OP_APP_SPEC |=> (spec_r & ~$past(spec_r)) == '0), "speculative mask gained bits outside an append")
  `SMTH_ASSERT(a_cleared_gone, (out_valid_r |-> (spec_r & cleared_r) == '0), "cleared bits still in the speculative mask")
  `SMTH_ASSERT(a_load_inits, (ctrl.load |=> ctrl.op == OP_INIT), "accepted word not followed by init step")

endmodule
`default_nettype wire

/* src/speculative_mod_tap_hold.sv */
// top level of the speculative mod-tap hold block
`default_nettype none
// speculative hold tracker for mod-tap keys. an event word is taken when start
// is high and busy is low; exactly one result word follows, shown for a single
// cycle with out_valid high, and the receiver cannot stall it, so it must take
// every word as it comes. busy stays high from the cycle after acceptance until
// the result is ready; a new event may be offered in the cycle the result word
// is on the ports. the time from acceptance to the result strobe is set by the
// walk over the list, a read step then an evaluate step per entry through the
// single registered read port of the entry memory, and by the shift after a
// hold of a found key, a read step then a write step per moved entry. the
// excluded modifier register may be written at any time the block is idle; it
// takes effect on the next event.
module speculative_mod_tap_hold #(
  parameter int LIST_DEPTH = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [smth_pkg::FIELD_W-1:0]  cfg_excluded_mod_mask,
  // event word
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_kind,
  input  wire logic                          in_pressed,
  input  wire logic                          in_is_mod_tap,
  input  wire logic                          in_is_matrix_event,
  input  wire logic [smth_pkg::POS_W-1:0]    in_key_row,
  input  wire logic [smth_pkg::POS_W-1:0]    in_key_col,
  input  wire logic [smth_pkg::FIELD_W-1:0]  in_mod_field,
  input  wire logic                          in_tap_count_zero,
  input  wire logic [smth_pkg::MOD_W-1:0]    in_current_mods,
  // result word
  output logic                               out_valid,
  output logic [smth_pkg::MOD_W-1:0]         out_spec_mods_out,
  output logic [smth_pkg::MOD_W-1:0]         out_removed_mods,
  output logic                               out_send_report,
  output logic                               out_overflow_clear
);
  import smth_pkg::*;

  // control word from the microprogram, branch flags back from the datapath
  ctrl_t  ctrl;
  flags_t flags;

  // sequencer: step counter walks the control store, branching on flags
  smth_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // datapath: entry memory, count, speculative mask and result registers
  smth_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ctrl                  (ctrl),
    .flags                 (flags),
    .cfg_we                (cfg_we),
    .cfg_excluded_mod_mask (cfg_excluded_mod_mask),
    .in_kind               (in_kind),
    .in_pressed            (in_pressed),
    .in_is_mod_tap         (in_is_mod_tap),
    .in_is_matrix_event    (in_is_matrix_event),
    .in_key_row            (in_key_row),
    .in_key_col            (in_key_col),
    .in_mod_field          (in_mod_field),
    .in_tap_count_zero     (in_tap_count_zero),
    .in_current_mods       (in_current_mods),
    .out_valid             (out_valid),
    .out_spec_mods_out     (out_spec_mods_out),
    .out_removed_mods      (out_removed_mods),
    .out_send_report       (out_send_report),
    .out_overflow_clear    (out_overflow_clear)
  );

endmodule
`default_nettype wire
